/* rtl/core/lct_pkg.sv */
package lct_pkg;

    // Item kinds
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;

    // Register byte offsets (low two bits are ignored on decode)
    localparam logic [4:0] OFS_LOAD_LO = 5'h00;
    localparam logic [4:0] OFS_LOAD_HI = 5'h04;
    localparam logic [4:0] OFS_CUR_LO  = 5'h08;
    localparam logic [4:0] OFS_CUR_HI  = 5'h0c;
    localparam logic [4:0] OFS_CTRL_A  = 5'h10;
    localparam logic [4:0] OFS_STATUS  = 5'h18;
    localparam logic [4:0] OFS_CTRL_B  = 5'h1c;
    localparam logic [4:0] OFS_MASK    = 5'h1c;

    // Control word bit positions
    localparam int CTRL_EN_BIT     = 0;
    localparam int CTRL_USER_BIT   = 1;
    localparam int CTRL_UNMASK_BIT = 2;
    localparam int CTRL_W          = 3;

    // Configuration register indexes
    localparam logic CFG_IDX_CTRL_ALT = 1'b0;

    typedef struct packed {
        logic [1:0]  mode;
        logic [4:0]  offset;
        logic [31:0] write_data;
    } t_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_line;
    } t_result;

endpackage

/* rtl/core/load_count_timer_peripheral_top.sv */
// 64-bit up-counting timer behind a small register file. Each request on the
// input channel is a tick, a register read or a register write; each yields
// exactly one result carrying read data (0 unless a read) and the masked
// interrupt line as it stands after the request. Requests pass an input
// register, are applied to the timer state (a 64-bit increment and compare)
// as they leave it, and land in an output register, which drives the result:
// one request per cycle is sustained while the output is not stalled. The APB
// port holds the control-word placement bit; the user writes it only while no
// request is in flight, which the block itself does not enforce.
module load_count_timer_peripheral_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [4:0]  i_offset,
    input  logic [31:0] i_write_data,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_read_data,
    output logic        o_irq_line,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic             r_in_valid;
    lct_pkg::t_item   r_in;
    logic             r_out_valid;
    lct_pkg::t_result r_out;

    logic             ctrl_alt;
    logic             advance;
    logic             in_load;
    lct_pkg::t_result result;

    lct_apb u_apb (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_ctrl_alt (ctrl_alt)
    );

    // Handshake: the stage moves when the output register is free or drains
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_load    = i_in_valid && !o_in_stall;

    lct_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (advance),
        .i_item     (r_in),
        .i_ctrl_alt (ctrl_alt),
        .o_result   (result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in.mode       <= i_mode;
            r_in.offset     <= i_offset;
            r_in.write_data <= i_write_data;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out.read_data;
    assign o_irq_line  = r_out.irq_line;

endmodule

/* rtl/core/lct_apb.sv */
module lct_apb (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic        o_ctrl_alt
);

    logic r_ctrl_alt;
    logic n_ctrl_alt;
    logic hit;

    // Only word 0 is backed; byte lanes within the word are ignored
    assign hit = (paddr[2] == lct_pkg::CFG_IDX_CTRL_ALT);

    always_comb begin
        n_ctrl_alt = r_ctrl_alt;
        if (psel && penable && pwrite && hit) begin
            n_ctrl_alt = pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_alt <= 1'b0;
        end else begin
            r_ctrl_alt <= n_ctrl_alt;
        end
    end

    assign prdata     = hit ? {31'd0, r_ctrl_alt} : 32'd0;
    assign pready     = 1'b1;
    assign o_ctrl_alt = r_ctrl_alt;

endmodule

/* rtl/core/lct_core.sv */
module lct_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  lct_pkg::t_item      i_item,
    input  logic                i_ctrl_alt,
    output lct_pkg::t_result    o_result
);

    logic [63:0]                r_count;
    logic [63:0]                n_count;
    logic [63:0]                r_load;
    logic [63:0]                n_load;
    logic [lct_pkg::CTRL_W-1:0] r_ctrl;
    logic [lct_pkg::CTRL_W-1:0] n_ctrl;
    logic                       r_pending;
    logic                       n_pending;

    logic [4:0]  ofs;
    logic [4:0]  ctrl_ofs;
    logic [63:0] count_inc;
    logic        at_load;
    logic [31:0] rd;

    assign ofs       = i_item.offset & lct_pkg::OFS_MASK;
    assign ctrl_ofs  = i_ctrl_alt ? lct_pkg::OFS_CTRL_B : lct_pkg::OFS_CTRL_A;
    assign count_inc = r_count + 64'd1;
    assign at_load   = (r_count == r_load);

    // Next state and read data for the request in the input register
    always_comb begin
        n_count   = r_count;
        n_load    = r_load;
        n_ctrl    = r_ctrl;
        n_pending = r_pending;
        rd        = 32'd0;
        case (i_item.mode)
            lct_pkg::MODE_TICK: begin
                if (r_ctrl[lct_pkg::CTRL_EN_BIT]) begin
                    if (at_load) begin
                        // free-running restarts, user mode holds
                        if (!r_ctrl[lct_pkg::CTRL_USER_BIT]) begin
                            n_count = 64'd0;
                            if (r_load == 64'd0) begin
                                n_pending = 1'b1;
                            end
                        end
                    end else begin
                        n_count = count_inc;
                        if (count_inc == r_load) begin
                            n_pending = 1'b1;
                        end
                    end
                end
            end
            lct_pkg::MODE_READ: begin
                if (ofs == ctrl_ofs) begin
                    rd = {{(32-lct_pkg::CTRL_W){1'b0}}, r_ctrl};
                end else begin
                    case (ofs)
                        lct_pkg::OFS_LOAD_LO: rd = r_load[31:0];
                        lct_pkg::OFS_LOAD_HI: rd = r_load[63:32];
                        lct_pkg::OFS_CUR_LO:  rd = r_count[31:0];
                        lct_pkg::OFS_CUR_HI:  rd = r_count[63:32];
                        lct_pkg::OFS_STATUS:  rd = {31'd0, r_pending};
                        default:              rd = 32'd0;
                    endcase
                end
            end
            lct_pkg::MODE_WRITE: begin
                if (ofs == ctrl_ofs) begin
                    n_ctrl = i_item.write_data[lct_pkg::CTRL_W-1:0];
                    // rising enable clears the counter
                    if (i_item.write_data[lct_pkg::CTRL_EN_BIT]
                        && !r_ctrl[lct_pkg::CTRL_EN_BIT]) begin
                        n_count = 64'd0;
                    end
                end else begin
                    case (ofs)
                        lct_pkg::OFS_LOAD_LO: n_load = {r_load[63:32], i_item.write_data};
                        lct_pkg::OFS_LOAD_HI: n_load = {i_item.write_data, r_load[31:0]};
                        lct_pkg::OFS_STATUS: begin
                            if (i_item.write_data[0]) begin
                                n_pending = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    // Timer state, updated as the request leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= 64'd0;
            r_load    <= 64'd0;
            r_ctrl    <= '0;
            r_pending <= 1'b0;
        end else if (i_fire) begin
            r_count   <= n_count;
            r_load    <= n_load;
            r_ctrl    <= n_ctrl;
            r_pending <= n_pending;
        end
    end

    assign o_result.read_data = rd;
    assign o_result.irq_line  = n_pending && n_ctrl[lct_pkg::CTRL_UNMASK_BIT];

endmodule
